### src/kfl_pkg.sv
// ----------------------------------------------------------------------------
// kfl_pkg: shared types and constants for the keyframe gap linear fill
// Beat payloads, sequencer states and divider request/response groups.
// ----------------------------------------------------------------------------
package kfl_pkg;

    localparam int VALUE_W   = 32;
    localparam int FRAME_W   = 6;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      is_key;
        logic                      track_end;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic [FRAME_W-1:0]        out_frame;
        logic                      run_last;
        logic                      track_done;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FILL,
        S_KEY,
        S_RD,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [FRAME_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quot;
        logic [FRAME_W-1:0] rem;
    } t_div_rsp;

endpackage

### src/kfl_div.sv
// ----------------------------------------------------------------------------
// kfl_div: restoring divider, one quotient bit per cycle
// 32-bit magnitude by a non-zero gap length; results held until next start.
// ----------------------------------------------------------------------------
module kfl_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kfl_pkg::t_div_req i_req,
    output kfl_pkg::t_div_rsp o_rsp
);

    logic                                r_busy;
    logic                                n_busy;
    logic                                r_done;
    logic                                n_done;
    logic [kfl_pkg::DIV_CNT_W-1:0]       r_cnt;
    logic [kfl_pkg::DIV_CNT_W-1:0]       n_cnt;
    logic [kfl_pkg::VALUE_W-1:0]         r_quot;
    logic [kfl_pkg::VALUE_W-1:0]         n_quot;
    logic [kfl_pkg::FRAME_W-1:0]         r_rem;
    logic [kfl_pkg::FRAME_W-1:0]         n_rem;
    logic [kfl_pkg::FRAME_W-1:0]         r_div;
    logic [kfl_pkg::FRAME_W-1:0]         n_div;
    logic [kfl_pkg::FRAME_W:0]           w_trial;
    logic [kfl_pkg::FRAME_W:0]           w_diff;
    logic                                w_ge;

    assign w_trial = {r_rem, r_quot[kfl_pkg::VALUE_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quot = i_req.dividend;
            n_rem  = '0;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            n_quot = {r_quot[kfl_pkg::VALUE_W-2:0], w_ge};
            n_rem  = w_ge ? w_diff[kfl_pkg::FRAME_W-1:0] : w_trial[kfl_pkg::FRAME_W-1:0];
            n_cnt  = r_cnt + kfl_pkg::DIV_CNT_W'(1);
            if (r_cnt == kfl_pkg::DIV_CNT_W'(kfl_pkg::DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

### src/kfl_buf.sv
// ----------------------------------------------------------------------------
// kfl_buf: pending-frame store
// One write and one registered read port; contents undefined until written.
// ----------------------------------------------------------------------------
module kfl_buf #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [kfl_pkg::VALUE_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [kfl_pkg::VALUE_W-1:0] o_rdata
);

    logic [kfl_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [kfl_pkg::VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/keyframe_gap_linear_fill.sv
// ----------------------------------------------------------------------------
// keyframe_gap_linear_fill: linear fill of the gaps between keyframes
// Waiting frames are taken back to back. A key with waiting frames runs the
// bit-serial divider, then gives a filled frame per waiting frame and the
// key; a key with none waiting, or a first frame, gives only the key. A track
// end on a waiting frame flushes the waiting frames (registered buffer read).
// Reset (synchronous, active low) clears control state; buffer is not swept.
// ----------------------------------------------------------------------------
module keyframe_gap_linear_fill #(
    parameter int FRAMES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  kfl_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output kfl_pkg::t_out o_data
);

    localparam int AW = $clog2(FRAMES);
    localparam int VW = kfl_pkg::VALUE_W;
    localparam int FW = kfl_pkg::FRAME_W;
    localparam int RW = kfl_pkg::FRAME_W + 2;

    // sequencer and track state
    kfl_pkg::t_state      r_state;
    kfl_pkg::t_state      n_state;
    logic [FW-1:0]        r_next_frame;
    logic [FW-1:0]        n_next_frame;
    logic [VW-1:0]        r_anchor_value;
    logic [VW-1:0]        n_anchor_value;
    logic [FW-1:0]        r_anchor_frame;
    logic [FW-1:0]        n_anchor_frame;
    logic [AW-1:0]        r_cnt;
    logic [AW-1:0]        n_cnt;
    logic [AW-1:0]        r_k;
    logic [AW-1:0]        n_k;

    // key in flight
    logic [VW-1:0]        r_key_value;
    logic [VW-1:0]        n_key_value;
    logic [FW-1:0]        r_key_frame;
    logic [FW-1:0]        n_key_frame;
    logic                 r_end;
    logic                 n_end;
    logic                 r_neg;
    logic                 n_neg;
    logic [FW-1:0]        r_g;
    logic [FW-1:0]        n_g;

    // running quotient/remainder of (2k|d| + g) / 2g
    logic [VW-1:0]        r_q;
    logic [VW-1:0]        n_q;
    logic [RW-1:0]        r_r;
    logic [RW-1:0]        n_r;

    // output register
    logic                 r_o_valid;
    logic                 n_o_valid;
    kfl_pkg::t_out        r_o_data;
    kfl_pkg::t_out        n_o_data;

    kfl_pkg::t_div_req    w_div_req;
    kfl_pkg::t_div_rsp    w_div_rsp;
    logic                 w_div_start;

    logic                 w_in_acc;
    logic                 w_end;
    logic                 w_out_free;
    logic [VW:0]          w_diff;
    logic [VW:0]          w_diff_neg;
    logic [AW-1:0]        w_k_inc;
    logic                 w_buf_we;
    logic                 w_buf_re;
    logic [VW-1:0]        w_buf_rdata;

    logic [RW-1:0]        w_r_sum;
    logic [RW-1:0]        w_g2;
    logic                 w_r_wrap;
    logic [RW-1:0]        w_r_next;
    logic [VW-1:0]        w_q_next;
    logic [VW+1:0]        w_fill_mag;
    logic [VW+1:0]        w_fill_sum;
    logic [FW-1:0]        w_fill_frame;

    assign w_in_acc   = i_valid && (r_state == kfl_pkg::S_IDLE);
    assign o_stall    = (r_state != kfl_pkg::S_IDLE);
    // the last possible frame index closes the track on its own
    assign w_end      = i_data.track_end || (r_next_frame >= FW'(FRAMES - 1));
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_k_inc    = r_k + AW'(1);

    // key minus anchor, one bit wider so it cannot overflow
    assign w_diff     = {i_data.sample_value[VW-1], i_data.sample_value}
                      - {r_anchor_value[VW-1], r_anchor_value};
    assign w_diff_neg = -w_diff;

    // one step along the gap: add 2|d| = A*2g + 2B, fold the remainder once
    assign w_r_sum    = r_r + RW'({w_div_rsp.rem, 1'b0});
    assign w_g2       = RW'({r_g, 1'b0});
    assign w_r_wrap   = (w_r_sum >= w_g2);
    assign w_r_next   = w_r_wrap ? (w_r_sum - w_g2) : w_r_sum;
    assign w_q_next   = r_q + w_div_rsp.quot + VW'(w_r_wrap);

    assign w_fill_mag   = {2'b00, w_q_next};
    assign w_fill_sum   = {{2{r_anchor_value[VW-1]}}, r_anchor_value}
                        + (r_neg ? -w_fill_mag : w_fill_mag);
    assign w_fill_frame = r_anchor_frame + FW'(r_k) + FW'(1);

    assign w_div_req.start    = w_div_start;
    assign w_div_req.dividend = w_diff[VW] ? w_diff_neg[VW-1:0] : w_diff[VW-1:0];
    assign w_div_req.divisor  = r_next_frame - r_anchor_frame;

    kfl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    kfl_buf #(
        .DEPTH (FRAMES),
        .AW    (AW)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_buf_we),
        .i_waddr (r_cnt),
        .i_wdata (i_data.sample_value),
        .i_re    (w_buf_re),
        .i_raddr (r_k),
        .o_rdata (w_buf_rdata)
    );

    always_comb begin
        n_state        = r_state;
        n_next_frame   = r_next_frame;
        n_anchor_value = r_anchor_value;
        n_anchor_frame = r_anchor_frame;
        n_cnt          = r_cnt;
        n_k            = r_k;
        n_key_value    = r_key_value;
        n_key_frame    = r_key_frame;
        n_end          = r_end;
        n_neg          = r_neg;
        n_g            = r_g;
        n_q            = r_q;
        n_r            = r_r;
        n_o_valid      = r_o_valid && i_stall;
        n_o_data       = r_o_data;
        w_div_start    = 1'b0;
        w_buf_we       = 1'b0;
        w_buf_re       = 1'b0;

        case (r_state)
            kfl_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_next_frame = w_end ? '0 : (r_next_frame + FW'(1));
                    if (r_next_frame == '0) begin
                        // first frame of a track is always an anchor
                        n_key_value = i_data.sample_value;
                        n_key_frame = '0;
                        n_end       = w_end;
                        n_cnt       = '0;
                        n_state     = kfl_pkg::S_KEY;
                    end else if (i_data.is_key) begin
                        n_key_value = i_data.sample_value;
                        n_key_frame = r_next_frame;
                        n_end       = w_end;
                        n_neg       = w_diff[VW];
                        n_g         = r_next_frame - r_anchor_frame;
                        if (r_cnt == '0) begin
                            n_state = kfl_pkg::S_KEY;
                        end else begin
                            w_div_start = 1'b1;
                            n_state     = kfl_pkg::S_DIV;
                        end
                    end else begin
                        w_buf_we = 1'b1;
                        n_cnt    = r_cnt + AW'(1);
                        n_k      = '0;
                        if (w_end) begin
                            n_state = kfl_pkg::S_RD;
                        end
                    end
                end
            end
            kfl_pkg::S_DIV: begin
                if (w_div_rsp.done) begin
                    n_q     = '0;
                    n_r     = RW'(r_g);
                    n_k     = '0;
                    n_state = kfl_pkg::S_FILL;
                end
            end
            kfl_pkg::S_FILL: begin
                if (w_out_free) begin
                    n_o_valid            = 1'b1;
                    n_o_data.out_value   = w_fill_sum[VW-1:0];
                    n_o_data.out_frame   = w_fill_frame;
                    n_o_data.run_last    = 1'b0;
                    n_o_data.track_done  = 1'b0;
                    n_q                  = w_q_next;
                    n_r                  = w_r_next;
                    n_k                  = w_k_inc;
                    if (w_k_inc == r_cnt) begin
                        n_state = kfl_pkg::S_KEY;
                    end
                end
            end
            kfl_pkg::S_KEY: begin
                if (w_out_free) begin
                    n_o_valid            = 1'b1;
                    n_o_data.out_value   = r_key_value;
                    n_o_data.out_frame   = r_key_frame;
                    n_o_data.run_last    = 1'b1;
                    n_o_data.track_done  = r_end;
                    n_anchor_value       = r_key_value;
                    n_anchor_frame       = r_key_frame;
                    n_cnt                = '0;
                    n_state              = kfl_pkg::S_IDLE;
                end
            end
            kfl_pkg::S_RD: begin
                w_buf_re = 1'b1;
                n_state  = kfl_pkg::S_FLUSH;
            end
            kfl_pkg::S_FLUSH: begin
                if (w_out_free) begin
                    n_o_valid            = 1'b1;
                    n_o_data.out_value   = w_buf_rdata;
                    n_o_data.out_frame   = w_fill_frame;
                    n_o_data.run_last    = (w_k_inc == r_cnt);
                    n_o_data.track_done  = (w_k_inc == r_cnt);
                    if (w_k_inc == r_cnt) begin
                        n_cnt   = '0;
                        n_state = kfl_pkg::S_IDLE;
                    end else begin
                        n_k     = w_k_inc;
                        n_state = kfl_pkg::S_RD;
                    end
                end
            end
            default: begin
                n_state = kfl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= kfl_pkg::S_IDLE;
            r_next_frame   <= '0;
            r_anchor_value <= '0;
            r_anchor_frame <= '0;
            r_cnt          <= '0;
            r_k            <= '0;
            r_o_valid      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_next_frame   <= n_next_frame;
            r_anchor_value <= n_anchor_value;
            r_anchor_frame <= n_anchor_frame;
            r_cnt          <= n_cnt;
            r_k            <= n_k;
            r_o_valid      <= n_o_valid;
        end
        r_key_value <= n_key_value;
        r_key_frame <= n_key_frame;
        r_end       <= n_end;
        r_neg       <= n_neg;
        r_g         <= n_g;
        r_q         <= n_q;
        r_r         <= n_r;
        r_o_data    <= n_o_data;
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

    // a beat that closes a track returns the frame counter to the start
    a_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_end) |=> (r_next_frame == '0))
        else $error("frame counter not cleared after track end");

    // the divider only reports back while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == kfl_pkg::S_DIV))
        else $error("divider result outside wait state");

    // filled frames lie strictly inside the gap
    a_fill_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kfl_pkg::S_FILL) |-> (w_fill_frame < r_key_frame))
        else $error("fill frame beyond key frame");

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for keyframe_gap_linear_fill
// Drives tracks of Q15.16 samples through the valid/stall input, predicts
// every filled, passed and flushed frame, and compares each output beat
// field by field against the oldest prediction. The idling on both sides
// runs through four phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAMES      = 64;
    localparam int unsigned QUIET_LIMIT = 4000;   // cycles without any beat

    // ------------------------------------------------------------------------
    // Frame predictor and store of expected output beats
    // ------------------------------------------------------------------------
    class fill_scoreboard;
        kfl_pkg::t_out      expected_q[$];
        int unsigned        errors;
        logic signed [31:0] anchor_val;
        logic [5:0]         anchor_frm;
        logic [6:0]         next_frm;
        logic signed [31:0] waiting[64];
        logic [6:0]         waiting_cnt;

        function new();
            errors      = 0;
            anchor_val  = '0;
            anchor_frm  = '0;
            next_frm    = '0;
            waiting_cnt = '0;
            foreach (waiting[i]) waiting[i] = '0;
        endfunction

        // point k of g along the line a..b, nearest, ties away from zero
        function automatic logic signed [31:0] line_point(longint a, longint b,
                                                          longint k, longint g);
            longint num;
            longint mag;
            longint q;
            num = (b - a) * k;
            mag = (num < 0) ? -num : num;
            q   = (2 * mag + g) / (2 * g);
            return 32'(a + ((num < 0) ? -q : q));
        endfunction

        function automatic kfl_pkg::t_out make_beat(logic signed [31:0] value,
                                                    logic [5:0] frame);
            kfl_pkg::t_out r;
            r.out_value  = value;
            r.out_frame  = frame;
            r.run_last   = 1'b0;
            r.track_done = 1'b0;
            return r;
        endfunction

        // an input beat was taken: work out the frames it releases
        function void note_beat(kfl_pkg::t_in d);
            kfl_pkg::t_out run[$];
            kfl_pkg::t_out r;
            logic [6:0]    frm;
            logic [5:0]    pos;
            logic          closes;
            longint        gap;
            frm    = next_frm;
            closes = d.track_end || (frm >= 7'(FRAMES - 1));
            if (frm == 0) begin
                // first frame of a track is always the anchor
                anchor_val  = d.sample_value;
                anchor_frm  = '0;
                waiting_cnt = '0;
                run.push_back(make_beat(d.sample_value, 6'd0));
            end else if (d.is_key) begin
                gap = longint'(frm) - longint'(anchor_frm);
                if (gap < 1) gap = 1;
                for (int i = 0; i < waiting_cnt; i++) begin
                    pos = 6'(anchor_frm + i + 1);
                    run.push_back(make_beat(line_point(anchor_val, d.sample_value,
                                                       i + 1, gap), pos));
                end
                run.push_back(make_beat(d.sample_value, frm[5:0]));
                anchor_val  = d.sample_value;
                anchor_frm  = frm[5:0];
                waiting_cnt = '0;
            end else begin
                if (waiting_cnt < 64) waiting[waiting_cnt[5:0]] = d.sample_value;
                waiting_cnt++;
                if (closes) begin
                    // no closing key: waiting frames leave unchanged
                    for (int i = 0; i < waiting_cnt; i++) begin
                        pos = 6'(anchor_frm + i + 1);
                        run.push_back(make_beat(waiting[i], pos));
                    end
                    waiting_cnt = '0;
                end
            end
            if (run.size() > 0) begin
                r          = run.pop_back();
                r.run_last = 1'b1;
                if (closes) r.track_done = 1'b1;
                run.push_back(r);
            end
            if (closes) begin
                next_frm    = '0;
                waiting_cnt = '0;
            end else begin
                next_frm = frm + 7'd1;
            end
            foreach (run[i]) expected_q.push_back(run[i]);
        endfunction

        function void report(string field, longint unsigned expv, longint unsigned gotv);
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, expv, gotv);
            errors++;
        endfunction

        function void check_beat(kfl_pkg::t_out got);
            kfl_pkg::t_out exp_beat;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected output beat, expected none, got %0h",
                         $time, got);
                errors++;
                return;
            end
            exp_beat = expected_q.pop_front();
            if (got.out_value !== exp_beat.out_value)
                report("out_value", exp_beat.out_value, got.out_value);
            if (got.out_frame !== exp_beat.out_frame)
                report("out_frame", exp_beat.out_frame, got.out_frame);
            if (got.run_last !== exp_beat.run_last)
                report("run_last", exp_beat.run_last, got.run_last);
            if (got.track_done !== exp_beat.track_done)
                report("track_done", exp_beat.track_done, got.track_done);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic          i_clk;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    kfl_pkg::t_in  i_data  = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    kfl_pkg::t_out o_data;

    fill_scoreboard sb;
    int unsigned    send_pct = 0;     // chance in 100 the sender idles before a beat, drawn anew while idle
    int unsigned    recv_pct = 0;     // chance in 100 the receiver stalls
    int unsigned    quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    keyframe_gap_linear_fill #(
        .FRAMES (FRAMES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_pct);
    end

    // Both channels sampled at the edge, pre-edge values: input beat noted
    // first so an output beat in the same cycle still finds its prediction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_beat(i_data);
            if (o_valid && !i_stall) sb.check_beat(o_data);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog: a hung handshake ends the run
    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // one input beat; valid stays high into the next beat when no idle falls
    task automatic send_beat(input logic signed [31:0] value, input logic key,
                             input logic last);
        while ($urandom_range(99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{sample_value: value, is_key: key, track_end: last};
        do @(posedge i_clk); while (o_stall);
    endtask

    // extremes, small values for rounding ties, and full random words
    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3:    return 32'(int'($urandom_range(8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    // A track of len frames; a full-length track leans on the frame limit,
    // so its last track_end is random. Noise may close a track early.
    task automatic send_track(input int unsigned len, input int unsigned key_pct,
                              input int unsigned noise_pct);
        logic last;
        for (int f = 0; f < len; f++) begin
            if (f == len - 1) last = (len == FRAMES) ? 1'($urandom_range(1)) : 1'b1;
            else              last = ($urandom_range(99) < noise_pct);
            send_beat(rand_value(), 1'($urandom_range(99) < key_pct), last);
        end
    endtask

    task automatic send_tracks(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 12);
            if ($urandom_range(5) == 0) send_track(len, 50, 15);   // broken tracks
            else                        send_track(len, $urandom_range(10, 60), 0);
            sent += len;
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase: no idling, directed tracks first
        send_pct = 0;
        recv_pct = 0;
        // first frame not key, at max; two waiting; key at min
        send_beat(32'sh7fff_ffff, 1'b0, 1'b0);
        send_beat(32'sd123,       1'b0, 1'b0);
        send_beat(-32'sd7,        1'b0, 1'b0);
        send_beat(32'sh8000_0000, 1'b1, 1'b0);
        // key straight after key: nothing waiting
        send_beat(32'sd0,         1'b1, 1'b0);
        // positive half-way tie rounds up
        send_beat(32'sd99,        1'b0, 1'b0);
        send_beat(32'sd1,         1'b1, 1'b0);
        // negative half-way tie rounds away from zero
        send_beat(32'sd555,       1'b0, 1'b0);
        send_beat(32'sd0,         1'b1, 1'b0);
        // track end on a waiting frame: flushed as is
        send_beat(32'sd77,        1'b0, 1'b1);
        // one-frame track
        send_beat(-32'sd5,        1'b1, 1'b1);
        // min to max gap, closed by a key that ends the track
        send_beat(32'sh8000_0000, 1'b1, 1'b0);
        send_beat(32'sh7fff_ffff, 1'b0, 1'b0);
        send_beat(32'sd0,         1'b0, 1'b0);
        send_beat(32'sh7fff_ffff, 1'b1, 1'b1);
        // no key after the anchor: three frames flushed at track end
        send_beat(32'sd10,        1'b0, 1'b0);
        send_beat(32'sd20,        1'b0, 1'b0);
        send_beat(32'sd30,        1'b0, 1'b0);
        send_beat(32'sd40,        1'b0, 1'b1);
        send_tracks(45);

        // phase: sender mostly idle; full track flushed at the frame limit
        send_pct = 84;
        send_track(FRAMES, 0, 0);
        send_tracks(45);

        // phase: receiver mostly stalling; full track with sparse keys
        send_pct = 0;
        recv_pct = 84;
        send_track(FRAMES, 2, 0);
        send_tracks(45);

        // phase: both sides idling now and then
        send_pct = 26;
        recv_pct = 26;
        send_tracks(45);

        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        // longest run (a full track flushed from the buffer) to catch stray extra beats
        repeat (150) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
